// ----- src/aelr_pkg.sv -----
// Shared constants, types and codes of the active edge line rasterizer.
package aelr_pkg;

    localparam int MAX_EDGES_DEF = 32;
    localparam int NUM_ROWS_DEF  = 48;
    localparam int TOP_ROW_DEF   = 24;
    localparam int FRAC_BITS_DEF = 16;

    localparam int X_W     = 11;  // pixel column
    localparam int Y_W     = 6;   // row coordinate
    localparam int FIX_W   = 32;  // fixed point x and step
    localparam int START_W = 6;   // stored start row
    localparam int ROWS_W  = 7;   // row count, up to 127

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_RANGE    = 3'd2,
        ST_HORIZ    = 3'd3,
        ST_FINISHED = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RESP,
        S_RD,
        S_EV,
        S_END
    } t_state;

    typedef struct packed {
        logic [START_W-1:0] start_row;
        logic [FIX_W-1:0]   x_fixed;
        logic [FIX_W-1:0]   step_fixed;
        logic [ROWS_W-1:0]  rows_left;
    } t_edge;

endpackage

// ----- src/aelr_div.sv -----
// Sequential signed divider: one quotient bit per cycle, truncated toward zero.
module aelr_div
    import aelr_pkg::*;
#(
    parameter int DW = 12 + FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [DW-1:0]  i_dividend,
    input  logic [ROWS_W-1:0]     i_divisor,
    output logic                  o_done,
    output logic [FIX_W-1:0]      o_quot
);
    localparam int CW = $clog2(DW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [ROWS_W-1:0] r_rem;
    logic [DW-1:0]     r_quo;
    logic [ROWS_W-1:0] r_div;
    logic              r_neg;

    logic [ROWS_W:0]   sh;
    logic              qbit;
    logic [ROWS_W:0]   diff;
    logic [DW-1:0]     q_signed;

    always_comb begin
        sh   = {r_rem, r_quo[DW-1]};
        diff = sh - {1'b0, r_div};
        qbit = (sh >= {1'b0, r_div});
        q_signed = r_neg ? (~r_quo + 1'b1) : r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DW-1];
            r_quo <= i_dividend[DW-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[ROWS_W-1:0] : sh[ROWS_W-1:0];
            r_quo <= {r_quo[DW-2:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = FIX_W'($signed(q_signed));

endmodule

// ----- src/active_edge_line_rasterizer_unit.sv -----
// Top level of the active edge line rasterizer: edge table, sequencer, result register.
//
// Usage: one request channel (i_valid / o_ready) carries a command and two
// endpoints; one result channel (o_valid / i_ready) carries pixels and status.
// A load request (cmd 0) checks the segment (horizontal, then out of range,
// then table full) and, if accepted, divides the x span by the row count and
// stores the edge. One result, pixel_valid 0, with the status.
// A raster request (cmd 1) scans the next row down: every stored edge that
// has started and has rows left gives one pixel, in load order; the last
// pixel carries last. A row with no pixel gives one empty result, and a
// raster request after all rows gives status "raster finished".
// Timing: a load waits for the one-bit-per-cycle divider. In a raster row
// each entry is read from the single-port edge memory and, if active, then
// updated and written back. A pixel is held back one edge so that last can
// be marked.
// Stall: results sit in an output register; when the receiver stalls the
// sequencer waits at the next pixel. A new request is taken once the previous
// one has been fully handed to the output register.
// Reset clears the edge count, the current row and all control; the edge
// memory itself is not cleared (only written entries are ever read).
module active_edge_line_rasterizer_unit
    import aelr_pkg::*;
#(
    parameter int MAX_EDGES = MAX_EDGES_DEF,
    parameter int NUM_ROWS  = NUM_ROWS_DEF,
    parameter int TOP_ROW   = TOP_ROW_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cmd,
    input  logic signed [X_W-1:0] i_x_first,
    input  logic signed [Y_W-1:0] i_y_first,
    input  logic signed [X_W-1:0] i_x_second,
    input  logic signed [Y_W-1:0] i_y_second,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [X_W-1:0] o_pixel_x,
    output logic signed [Y_W-1:0] o_pixel_y,
    output logic                  o_pixel_valid,
    output logic [2:0]            o_status,
    output logic                  o_last
);
    localparam int IDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNT_W = $clog2(MAX_EDGES + 1);
    localparam int ROW_W = $clog2(NUM_ROWS + 1);
    localparam int DW    = 12 + FRAC_BITS;

    // edge table
    t_edge r_mem [MAX_EDGES];
    t_edge r_rd;

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_count;
    logic [ROW_W-1:0]  r_row;
    logic [CNT_W-1:0]  r_idx;
    logic              r_pend;
    logic [X_W-1:0]    r_pend_x;
    t_status           r_resp;

    // load operands held during divide
    logic [START_W-1:0] r_ld_start;
    logic [FIX_W-1:0]   r_ld_x;
    logic [ROWS_W-1:0]  r_ld_rows;

    logic               r_o_valid;
    logic [X_W-1:0]     r_o_x;
    logic [Y_W-1:0]     r_o_y;
    logic               r_o_pv;
    t_status            r_o_status;
    logic               r_o_last;

    // request decode
    logic               accept;
    logic signed [8:0]  r1, r2;
    logic               horiz, out_range, full;
    logic               first_high;
    logic signed [X_W-1:0] xh, xl;
    logic signed [Y_W-1:0] yh, yl;
    logic signed [X_W:0]   dx;
    logic [ROWS_W-1:0]  rows;
    logic signed [DW-1:0] dividend;

    logic               div_start, div_done;
    logic [FIX_W-1:0]   div_quot;

    // raster datapath
    logic               slot_free;
    logic               out_load;
    logic               active;
    logic               last_idx;
    logic signed [FIX_W-1:0] xs;
    logic [FIX_W-1:0]   xmag, xtr;
    logic [X_W-1:0]     cur_px;
    logic [Y_W-1:0]     cur_py;

    assign accept    = i_valid && o_ready;
    assign o_ready   = (r_state == S_IDLE);
    assign slot_free = !r_o_valid || i_ready;
    // output register takes a new result this cycle
    assign out_load  = slot_free && ((r_state == S_RESP) || (r_state == S_END)
                                     || ((r_state == S_EV) && active && r_pend));

    always_comb begin
        r1 = $signed(9'(TOP_ROW)) - 9'(i_y_first);
        r2 = $signed(9'(TOP_ROW)) - 9'(i_y_second);
        horiz = (i_y_first == i_y_second);
        out_range = (r1 < 0) || (r1 >= $signed(9'(NUM_ROWS)))
                 || (r2 < 0) || (r2 >= $signed(9'(NUM_ROWS)));
        full = (r_count >= CNT_W'(MAX_EDGES));
        first_high = (i_y_first > i_y_second);
        xh = first_high ? i_x_first  : i_x_second;
        yh = first_high ? i_y_first  : i_y_second;
        xl = first_high ? i_x_second : i_x_first;
        yl = first_high ? i_y_second : i_y_first;
        dx = (X_W+1)'(xl) - (X_W+1)'(xh);
        rows = ROWS_W'(8'(yh) - 8'(yl) + 8'd1);
        dividend = DW'(dx) <<< FRAC_BITS;
    end

    always_comb begin
        active = ({2'b0, r_rd.start_row} <= 8'(r_row)) && (r_rd.rows_left != '0);
        last_idx = (r_idx + 1'b1 == r_count);
        xs = $signed(r_rd.x_fixed);
        xmag = xs[FIX_W-1] ? (~r_rd.x_fixed + 1'b1) : r_rd.x_fixed;
        xtr = xmag >> FRAC_BITS;
        cur_px = xs[FIX_W-1] ? X_W'(~xtr + 1'b1) : X_W'(xtr);
        cur_py = Y_W'(8'(TOP_ROW) - 8'(r_row));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd) begin
                        if (r_row >= ROW_W'(NUM_ROWS)) n_state = S_RESP;
                        else if (r_count == '0)      n_state = S_END;
                        else                         n_state = S_RD;
                    end else if (horiz || out_range || full) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV:  if (div_done) n_state = S_RESP;
            S_RESP: if (slot_free) n_state = S_IDLE;
            S_RD:   n_state = S_EV;
            S_EV: begin
                if (!active || !r_pend || slot_free)
                    n_state = last_idx ? S_END : S_RD;
            end
            S_END:  if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign div_start = (r_state == S_IDLE) && accept && !i_cmd
                    && !horiz && !out_range && !full;

    aelr_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (rows),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // control and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_row     <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
            r_resp    <= ST_OK;
        end else begin
            r_state <= n_state;
            if (out_load)     r_o_valid <= 1'b1;
            else if (i_ready) r_o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_idx  <= '0;
                    r_pend <= 1'b0;
                    if (accept) begin
                        if (i_cmd)          r_resp <= ST_FINISHED;
                        else if (horiz)     r_resp <= ST_HORIZ;
                        else if (out_range) r_resp <= ST_RANGE;
                        else if (full)      r_resp <= ST_FULL;
                        else                r_resp <= ST_OK;
                    end
                end
                S_DIV: begin
                    if (div_done) r_count <= r_count + 1'b1;
                end
                S_RESP: begin
                    if (slot_free) begin
                        r_o_x      <= '0;
                        r_o_y      <= '0;
                        r_o_pv     <= 1'b0;
                        r_o_status <= r_resp;
                        r_o_last   <= 1'b1;
                    end
                end
                S_RD: ;
                S_EV: begin
                    if (active && r_pend && slot_free) begin
                        r_o_x      <= r_pend_x;
                        r_o_y      <= cur_py;
                        r_o_pv     <= 1'b1;
                        r_o_status <= ST_OK;
                        r_o_last   <= 1'b0;
                    end
                    if (!active || !r_pend || slot_free) begin
                        r_idx <= r_idx + 1'b1;
                        if (active) begin
                            r_pend   <= 1'b1;
                            r_pend_x <= cur_px;
                        end
                    end
                end
                S_END: begin
                    if (slot_free) begin
                        r_o_x      <= r_pend ? r_pend_x : '0;
                        r_o_y      <= r_pend ? cur_py : '0;
                        r_o_pv     <= r_pend;
                        r_o_status <= ST_OK;
                        r_o_last   <= 1'b1;
                        r_row      <= r_row + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // load operands
    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_ld_start <= START_W'(8'(TOP_ROW) - 8'(yh));
            r_ld_x     <= FIX_W'(xh) << FRAC_BITS;
            r_ld_rows  <= rows;
        end
    end

    // edge memory: one read or one write per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && div_done) begin
            r_mem[r_count[IDX_W-1:0]] <= '{start_row:  r_ld_start,
                                           x_fixed:    r_ld_x,
                                           step_fixed: div_quot,
                                           rows_left:  r_ld_rows};
        end else if (r_state == S_EV && active && (!r_pend || slot_free)) begin
            r_mem[r_idx[IDX_W-1:0]] <= '{start_row:  r_rd.start_row,
                                         x_fixed:    r_rd.x_fixed + r_rd.step_fixed,
                                         step_fixed: r_rd.step_fixed,
                                         rows_left:  r_rd.rows_left - 1'b1};
        end
        if (r_state == S_RD) r_rd <= r_mem[r_idx[IDX_W-1:0]];
    end

    assign o_valid       = r_o_valid;
    assign o_pixel_x     = r_o_x;
    assign o_pixel_y     = r_o_y;
    assign o_pixel_valid = r_o_pv;
    assign o_status      = r_o_status;
    assign o_last        = r_o_last;

endmodule
